>>> design/glcw_pkg.sv
// Shared types and constants for the grid line cell walk block.
// Used by the controller, the datapath, the top level and the checker.
package glcw_pkg;

    // Fixed width of one input coordinate (signed, fraction bits included)
    localparam int IN_BITS = 20;
    // Width of the crossing-distance accumulators
    localparam int ACC_BITS = 40;

    // Parameter defaults
    localparam int MAX_CELLS_DEF = 64;
    localparam int FRAC_BITS_DEF = 8;
    localparam int CELL_BITS_DEF = 12;

    // Packed input word width: four coordinates
    localparam int IN_DATA_W = ((4 * IN_BITS + 7) / 8) * 8;

    // Walk mode of the current segment
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_X    = 2'd1,
        MODE_Y    = 2'd2,
        MODE_DDA  = 2'd3
    } walk_mode_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the input word
        logic setup;     // floors, deltas, mode, cell count
        logic mul_x;     // cross_x = dist_x * |dy|
        logic mul_y;     // cross_y = dist_y * |dx|
        logic step;      // emit one cell and advance
    } glcw_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
        logic last_cell; // the next emitted cell ends the run
    } glcw_status_t;

endpackage

>>> design/grid_line_cell_walk_unit.sv
// After a segment is accepted, the sequencer runs setup, two passes through
// the shared multiplier and then the walk, one cell per cycle while the output
// is free; a run holds count = min(|dfloor x|+|dfloor y|+1, MAX_CELLS) cells.
// No new segment is taken until the last cell of the run has been stepped out.
// Reset (rst_n, async, active low) returns the sequencer to idle and
// clears the output valid; no item is held across reset.
module grid_line_cell_walk_unit
#(
    parameter int MAX_CELLS = glcw_pkg::MAX_CELLS_DEF,
    parameter int FRAC_BITS = glcw_pkg::FRAC_BITS_DEF,
    parameter int CELL_BITS = glcw_pkg::CELL_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata from bit 0 up: start_x, start_y, end_x, end_y
    input  logic [glcw_pkg::IN_DATA_W-1:0]          s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata from bit 0 up: cell_x, cell_y, zero fill to whole bytes
    output logic [((2*CELL_BITS+7)/8)*8-1:0]        m_axis_tdata,
    output logic                                    m_axis_tlast,
    // tuser from bit 0 up: truncated
    output logic [0:0]                              m_axis_tuser
);

    localparam int OUT_DATA_W = ((2 * CELL_BITS + 7) / 8) * 8;

    glcw_pkg::glcw_cmd_t    cmd;
    glcw_pkg::glcw_status_t status;

    logic signed [CELL_BITS-1:0] cell_x, cell_y;
    logic                        truncated;

    glcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    glcw_datapath
    #(
        .MAX_CELLS (MAX_CELLS),
        .FRAC_BITS (FRAC_BITS),
        .CELL_BITS (CELL_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_data       (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_cell_x    (cell_x),
        .out_cell_y    (cell_y),
        .out_last      (m_axis_tlast),
        .out_truncated (truncated)
    );

    // Output word packing
    assign m_axis_tdata = OUT_DATA_W'({cell_y, cell_x});
    assign m_axis_tuser = truncated;

endmodule

>>> design/glcw_ctrl.sv
// Sequencer for the grid line cell walk: setup, two multiply steps, walk.
// Depends on glcw_pkg for the command and status structs.
module glcw_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  glcw_pkg::glcw_status_t status,
    output glcw_pkg::glcw_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL_X,
        ST_MUL_Y,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_MUL_X;
            ST_MUL_X: state_next = ST_MUL_Y;
            ST_MUL_Y: state_next = ST_WALK;
            ST_WALK:
            begin
                if (status.out_free && status.last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands decoded from state
    assign in_ready    = (state_reg == ST_IDLE);
    assign cmd.capture = (state_reg == ST_IDLE) && in_valid;
    assign cmd.setup   = (state_reg == ST_SETUP);
    assign cmd.mul_x   = (state_reg == ST_MUL_X);
    assign cmd.mul_y   = (state_reg == ST_MUL_Y);
    assign cmd.step    = (state_reg == ST_WALK) && status.out_free;

endmodule

>>> design/glcw_datapath.sv
// Datapath of the grid line cell walk: input latch, setup arithmetic,
// shared multiplier, DDA step logic and output register. Uses glcw_pkg.
module glcw_datapath
#(
    parameter int MAX_CELLS = glcw_pkg::MAX_CELLS_DEF,
    parameter int FRAC_BITS = glcw_pkg::FRAC_BITS_DEF,
    parameter int CELL_BITS = glcw_pkg::CELL_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [glcw_pkg::IN_DATA_W-1:0]        in_data,
    input  glcw_pkg::glcw_cmd_t                   cmd,
    output glcw_pkg::glcw_status_t                status,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [CELL_BITS-1:0]           out_cell_x,
    output logic signed [CELL_BITS-1:0]           out_cell_y,
    output logic                                  out_last,
    output logic                                  out_truncated
);

    localparam int IN_BITS  = glcw_pkg::IN_BITS;
    localparam int ACC_BITS = glcw_pkg::ACC_BITS;
    localparam int FLOOR_W  = IN_BITS - FRAC_BITS;
    localparam int TOT_W    = FLOOR_W + 3;
    localparam int CNT_W    = $clog2(MAX_CELLS + 1);
    localparam int PROD_W   = FRAC_BITS + 1 + IN_BITS + 1;
    localparam logic [FRAC_BITS:0] DIST_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Latched segment
    logic signed [IN_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    // Walk state
    logic signed [CELL_BITS-1:0] cell_x_reg, cell_y_reg;
    logic                        neg_x_reg, neg_y_reg;
    glcw_pkg::walk_mode_t        mode_reg;
    logic [CNT_W-1:0]            left_reg;
    logic                        cut_reg;
    logic [IN_BITS:0]            adx_reg, ady_reg;
    logic [FRAC_BITS:0]          dist_x_reg, dist_y_reg;
    logic [ACC_BITS-1:0]         acc_x_reg, acc_y_reg;

    // Output register
    logic                        out_valid_reg;
    logic signed [CELL_BITS-1:0] out_x_reg, out_y_reg;
    logic                        out_last_reg, out_trunc_reg;

    // Setup arithmetic
    logic signed [FLOOR_W-1:0] fsx, fsy, fex, fey;
    logic signed [IN_BITS:0]   dx, dy;
    logic [IN_BITS:0]          adx, ady;
    logic signed [FLOOR_W:0]   fdx, fdy;
    logic [FLOOR_W:0]          afdx, afdy;
    logic [TOT_W-1:0]          total;
    logic                      cut;
    logic [CNT_W-1:0]          count;
    logic [FRAC_BITS-1:0]      fx, fy;
    logic                      neg_x, neg_y;
    glcw_pkg::walk_mode_t      mode;

    always_comb
    begin
        fsx   = sx_reg[IN_BITS-1:FRAC_BITS];
        fsy   = sy_reg[IN_BITS-1:FRAC_BITS];
        fex   = ex_reg[IN_BITS-1:FRAC_BITS];
        fey   = ey_reg[IN_BITS-1:FRAC_BITS];
        dx    = (IN_BITS+1)'(ex_reg) - (IN_BITS+1)'(sx_reg);
        dy    = (IN_BITS+1)'(ey_reg) - (IN_BITS+1)'(sy_reg);
        neg_x = dx[IN_BITS];
        neg_y = dy[IN_BITS];
        adx   = neg_x ? (~dx + 1'b1) : dx;
        ady   = neg_y ? (~dy + 1'b1) : dy;
        fdx   = (FLOOR_W+1)'(fex) - (FLOOR_W+1)'(fsx);
        fdy   = (FLOOR_W+1)'(fey) - (FLOOR_W+1)'(fsy);
        afdx  = fdx[FLOOR_W] ? (~fdx + 1'b1) : fdx;
        afdy  = fdy[FLOOR_W] ? (~fdy + 1'b1) : fdy;
        total = TOT_W'(afdx) + TOT_W'(afdy) + TOT_W'(1);
        cut   = 32'(total) > 32'(MAX_CELLS);
        count = cut ? CNT_W'(MAX_CELLS) : CNT_W'(total);
        fx    = sx_reg[FRAC_BITS-1:0];
        fy    = sy_reg[FRAC_BITS-1:0];
        // Horizontal segment walks along x, same column walks along y
        priority if (sy_reg == ey_reg)
        begin
            mode = glcw_pkg::MODE_X;
        end
        else if (fsx == fex)
        begin
            mode = glcw_pkg::MODE_Y;
        end
        else
        begin
            mode = glcw_pkg::MODE_DDA;
        end
    end

    // Shared multiplier for the two initial crossing distances
    logic [FRAC_BITS:0]  mul_a;
    logic [IN_BITS:0]    mul_b;
    logic [PROD_W-1:0]   product;

    assign mul_a   = cmd.mul_x ? dist_x_reg : dist_y_reg;
    assign mul_b   = cmd.mul_x ? ady_reg : adx_reg;
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Step decision and accumulator advance
    logic                 fin;
    logic                 go_x;
    logic [ACC_BITS-1:0]  stride_x, stride_y;

    assign fin      = (left_reg == CNT_W'(1));
    assign stride_x = ACC_BITS'(ady_reg) << FRAC_BITS;
    assign stride_y = ACC_BITS'(adx_reg) << FRAC_BITS;

    always_comb
    begin
        unique case (mode_reg)
            glcw_pkg::MODE_X:   go_x = 1'b1;
            glcw_pkg::MODE_Y:   go_x = 1'b0;
            glcw_pkg::MODE_DDA: go_x = acc_x_reg < acc_y_reg;  // tie steps y
            default:            go_x = 1'b0;
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sx_reg <= in_data[IN_BITS-1:0];
            sy_reg <= in_data[2*IN_BITS-1:IN_BITS];
            ex_reg <= in_data[3*IN_BITS-1:2*IN_BITS];
            ey_reg <= in_data[4*IN_BITS-1:3*IN_BITS];
        end

        if (cmd.setup)
        begin
            cell_x_reg <= CELL_BITS'(fsx);
            cell_y_reg <= CELL_BITS'(fsy);
            neg_x_reg  <= neg_x;
            neg_y_reg  <= neg_y;
            cut_reg    <= cut;
            adx_reg    <= adx;
            ady_reg    <= ady;
            dist_x_reg <= neg_x ? (FRAC_BITS+1)'(fx) : DIST_ONE - (FRAC_BITS+1)'(fx);
            dist_y_reg <= neg_y ? (FRAC_BITS+1)'(fy) : DIST_ONE - (FRAC_BITS+1)'(fy);
        end

        if (cmd.mul_x)
        begin
            acc_x_reg <= ACC_BITS'(product);
        end
        if (cmd.mul_y)
        begin
            acc_y_reg <= ACC_BITS'(product);
        end

        if (cmd.step)
        begin
            out_x_reg     <= cell_x_reg;
            out_y_reg     <= cell_y_reg;
            out_last_reg  <= fin;
            out_trunc_reg <= fin && cut_reg;
            if (!fin)
            begin
                if (go_x)
                begin
                    cell_x_reg <= neg_x_reg ? cell_x_reg - CELL_BITS'(1)
                                            : cell_x_reg + CELL_BITS'(1);
                    if (mode_reg == glcw_pkg::MODE_DDA)
                    begin
                        acc_x_reg <= acc_x_reg + stride_x;
                    end
                end
                else
                begin
                    cell_y_reg <= neg_y_reg ? cell_y_reg - CELL_BITS'(1)
                                            : cell_y_reg + CELL_BITS'(1);
                    if (mode_reg == glcw_pkg::MODE_DDA)
                    begin
                        acc_y_reg <= acc_y_reg + stride_y;
                    end
                end
            end
        end
    end

    // Control registers: mode, cells left, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= glcw_pkg::MODE_IDLE;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.setup)
            begin
                mode_reg <= mode;
                left_reg <= count;
            end
            else if (cmd.step)
            begin
                left_reg <= left_reg - CNT_W'(1);
                if (fin)
                begin
                    mode_reg <= glcw_pkg::MODE_IDLE;
                end
            end

            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_cell = fin;

    assign out_valid     = out_valid_reg;
    assign out_cell_x    = out_x_reg;
    assign out_cell_y    = out_y_reg;
    assign out_last      = out_last_reg;
    assign out_truncated = out_trunc_reg;

endmodule

>>> design/glcw_checker.sv
// Port-level checks for grid_line_cell_walk_unit, bound to the top level.
// Depends on glcw_pkg for the default cell width.
module glcw_checker
#(
    parameter int CELL_BITS = glcw_pkg::CELL_BITS_DEF
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((2*CELL_BITS+7)/8)*8-1:0]     m_axis_tdata,
    input logic                                 m_axis_tlast,
    input logic [0:0]                           m_axis_tuser
);

    // Output word holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

    // Truncation is only flagged on the last cell of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("truncated set on a cell that is not last");

    // A taken segment keeps the input closed while it is set up
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened during segment setup");

    // Output valid is cleared by reset, so it is low on the edge after a reset cycle
    assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind grid_line_cell_walk_unit glcw_checker
#(
    .CELL_BITS (CELL_BITS)
)
u_glcw_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/grid_line_cell_walk_unit_tb.sv
// Self-checking bench for grid_line_cell_walk_unit: segments in, visited grid cells out.
// Depends on glcw_pkg and the block's RTL; every cell word is predicted here.
module grid_line_cell_walk_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CELLS   = glcw_pkg::MAX_CELLS_DEF;
    localparam int FRAC_BITS   = glcw_pkg::FRAC_BITS_DEF;
    localparam int CELL_BITS   = glcw_pkg::CELL_BITS_DEF;
    localparam int IN_BITS     = glcw_pkg::IN_BITS;
    localparam int ACC_BITS    = glcw_pkg::ACC_BITS;
    localparam int IN_DATA_W   = glcw_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = ((2 * CELL_BITS + 7) / 8) * 8;
    localparam int ONE_CELL    = 1 << FRAC_BITS;
    localparam int COORD_MIN   = -(1 << (IN_BITS - 1));
    localparam int COORD_MAX   = (1 << (IN_BITS - 1)) - 1;
    localparam int IDLE_PCT    = 23;
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_SEGS = 330;
    localparam int SETTLE_CYC  = 8;

    typedef logic signed [IN_BITS-1:0] coord_t;

    typedef struct packed {
        logic signed [CELL_BITS-1:0] cx;
        logic signed [CELL_BITS-1:0] cy;
        logic                        last;
        logic                        trunc;
    } grid_cell_t;

    // Walks each accepted segment and holds the cells still owed by the block
    class cell_walk_checker;
        grid_cell_t cells_due[$];
        int         errors;

        function void expect_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            longint               dx, dy, fsx, fsy, fex, fey, adx, ady;
            longint               span_x, span_y, total, pos_x, pos_y, dist_x, dist_y;
            int                   count;
            bit                   cut, neg_x, neg_y, go_x;
            glcw_pkg::walk_mode_t mode;
            logic [ACC_BITS-1:0]  cross_x, cross_y;
            grid_cell_t           c;

            dx     = longint'(ex) - longint'(sx);
            dy     = longint'(ey) - longint'(sy);
            fsx    = longint'(sx) >>> FRAC_BITS;
            fsy    = longint'(sy) >>> FRAC_BITS;
            fex    = longint'(ex) >>> FRAC_BITS;
            fey    = longint'(ey) >>> FRAC_BITS;
            adx    = (dx < 0) ? -dx : dx;
            ady    = (dy < 0) ? -dy : dy;
            span_x = (fex < fsx) ? fsx - fex : fex - fsx;
            span_y = (fey < fsy) ? fsy - fey : fey - fsy;
            total  = span_x + span_y + 1;
            cut    = total > MAX_CELLS;
            count  = cut ? MAX_CELLS : int'(total);
            neg_x  = dx < 0;
            neg_y  = dy < 0;
            pos_x  = fsx;
            pos_y  = fsy;

            if (sy == ey)
                mode = glcw_pkg::MODE_X;
            else if (fsx == fex)
                mode = glcw_pkg::MODE_Y;
            else
                mode = glcw_pkg::MODE_DDA;

            // distance to the next grid line, scaled by the other axis delta
            dist_x  = neg_x ? longint'(sx[FRAC_BITS-1:0])
                            : ONE_CELL - longint'(sx[FRAC_BITS-1:0]);
            dist_y  = neg_y ? longint'(sy[FRAC_BITS-1:0])
                            : ONE_CELL - longint'(sy[FRAC_BITS-1:0]);
            cross_x = ACC_BITS'(dist_x * ady);
            cross_y = ACC_BITS'(dist_y * adx);

            for (int k = 0; k < count; k++)
            begin
                c.cx    = pos_x[CELL_BITS-1:0];
                c.cy    = pos_y[CELL_BITS-1:0];
                c.last  = (k == count - 1);
                c.trunc = c.last && cut;
                cells_due.push_back(c);
                if (c.last)
                    break;

                // tie goes to y
                if (mode == glcw_pkg::MODE_X)
                    go_x = 1'b1;
                else if (mode == glcw_pkg::MODE_Y)
                    go_x = 1'b0;
                else
                    go_x = cross_x < cross_y;

                if (go_x)
                begin
                    pos_x = neg_x ? pos_x - 1 : pos_x + 1;
                    if (mode == glcw_pkg::MODE_DDA)
                        cross_x = cross_x + ACC_BITS'(ONE_CELL * ady);
                end
                else
                begin
                    pos_y = neg_y ? pos_y - 1 : pos_y + 1;
                    if (mode == glcw_pkg::MODE_DDA)
                        cross_y = cross_y + ACC_BITS'(ONE_CELL * adx);
                end
            end
        endfunction

        function void check_cell(logic signed [CELL_BITS-1:0] cx,
                                 logic signed [CELL_BITS-1:0] cy,
                                 logic last, logic trunc);
            grid_cell_t want;

            if (cells_due.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected cell word x=%0d y=%0d last=%0b trunc=%0b",
                             $time, cx, cy, last, trunc);
                return;
            end
            want = cells_due.pop_front();
            if (cx !== want.cx || cy !== want.cy || last !== want.last || trunc !== want.trunc)
            begin
                errors++;
                if (errors <= 40)
                    $display({"%0t: cell mismatch, expected x=%0d y=%0d last=%0b trunc=%0b,",
                              " got x=%0d y=%0d last=%0b trunc=%0b"},
                             $time, want.cx, want.cy, want.last, want.trunc,
                             cx, cy, last, trunc);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;

    cell_walk_checker walk = new();
    bit               steady = 1'b0;
    int               quiet_cycles = 0;

    grid_line_cell_walk_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("grid_line_cell_walk_unit_tb failed");
                $finish;
            end
        end
    end

    // Output side: check at rising edge, pick next ready at falling edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                walk.check_cell(m_axis_tdata[CELL_BITS-1:0],
                                m_axis_tdata[2*CELL_BITS-1:CELL_BITS],
                                m_axis_tlast, m_axis_tuser[0]);
            @(negedge clk);
            m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic coord_t clamp_coord(longint v);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        return coord_t'(v);
    endfunction

    function automatic longint rand_offset(int reach);
        return longint'($urandom_range(2 * reach)) - reach;
    endfunction

    // Present one segment word and hold it until the block takes it
    task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int gap;

        gap = 0;
        if (!steady && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(1, 40);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {ey, ex, sy, sx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        walk.expect_segment(sx, sy, ex, ey);
    endtask

    // Directed segment given as plain integer coordinates
    task automatic send_coords(int sx, int sy, int ex, int ey);
        send_segment(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
    endtask

    // Hold off until every owed cell has come out
    task automatic drain_cells();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (walk.cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Random segment, mostly short walks with special shapes mixed in
    task automatic random_segment(output coord_t sx, output coord_t sy,
                                  output coord_t ex, output coord_t ey);
        int pick;

        pick = $urandom_range(99);
        sx   = coord_t'($urandom());
        sy   = coord_t'($urandom());
        if (pick < 45)
        begin
            ex = clamp_coord(sx + rand_offset(8 * ONE_CELL));
            ey = clamp_coord(sy + rand_offset(8 * ONE_CELL));
        end
        else if (pick < 55)
        begin
            ex = clamp_coord(sx + rand_offset(20 * ONE_CELL));
            ey = sy;
        end
        else if (pick < 65)
        begin
            ex = {sx[IN_BITS-1:FRAC_BITS], FRAC_BITS'($urandom())};
            ey = clamp_coord(sy + rand_offset(20 * ONE_CELL));
        end
        else if (pick < 80)
        begin
            // starts on grid lines, sometimes ends on them too
            sx[FRAC_BITS-1:0] = '0;
            sy[FRAC_BITS-1:0] = '0;
            ex = clamp_coord(sx + rand_offset(6) * ONE_CELL);
            ey = clamp_coord(sy + rand_offset(6) * ONE_CELL);
            if ($urandom_range(1))
            begin
                ex[FRAC_BITS-1:0] = FRAC_BITS'($urandom());
                ey[FRAC_BITS-1:0] = FRAC_BITS'($urandom());
            end
        end
        else if (pick < 90)
        begin
            ex = clamp_coord(sx + rand_offset(80 * ONE_CELL));
            ey = clamp_coord(sy + rand_offset(80 * ONE_CELL));
        end
        else
        begin
            ex = coord_t'($urandom());
            ey = coord_t'($urandom());
        end
    endtask

    // Main sequence
    initial
    begin
        coord_t sx, sy, ex, ey;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: modes, ties, grid-line starts, run limit, coordinate extremes
        send_coords(1408, 832, 1408, 832);           // start equals end
        send_coords(384, 640, 1600, 640);            // along x, positive
        send_coords(768, -384, -1216, -384);         // along x, negative from grid line
        send_coords(589, 256, 742, 1920);            // along y, positive
        send_coords(-896, 0, -794, -1536);           // along y, negative
        send_coords(512, 1280, 512, 256);            // along y, no x delta
        send_coords(128, 128, 640, 640);             // diagonal, a tie at each corner crossing
        send_coords(0, 0, 768, 768);                 // corner to corner
        send_coords(0, 0, -768, -512);               // both axes on grid lines, negative
        send_coords(1024, 384, 384, 819);            // x on grid line, negative
        send_coords(-333, 691, 1434, -819);          // general
        send_coords(26, 51, 486, 5299);              // steep
        send_coords(51, 77, 947, 154);               // DDA with x steps only
        send_coords(128, 128, -512, -768);           // ends on grid lines
        send_coords(0, 0, 63 * ONE_CELL + 128, 0);   // exactly the run limit
        send_coords(0, 0, 64 * ONE_CELL, 0);         // one over the run limit
        send_coords(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_coords(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_coords(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_coords(COORD_MIN, 0, COORD_MAX, 0);
        send_coords(COORD_MAX, -1, COORD_MIN, -1);
        send_coords(307, 384, 460, 384);             // single cell along x
        send_coords(0, COORD_MIN, 255, COORD_MAX);   // long vertical, cut
        drain_cells();

        // random segments, a burst without idling in the middle
        for (int n = 0; n < RANDOM_SEGS; n++)
        begin
            steady = (n >= 150 && n < 230);
            if (n == 100)
                drain_cells();
            random_segment(sx, sy, ex, ey);
            send_segment(sx, sy, ex, ey);
        end
        steady = 1'b0;
        drain_cells();

        if (walk.errors == 0 && walk.cells_due.size() == 0)
            $display("grid_line_cell_walk_unit_tb passed");
        else
            $display("grid_line_cell_walk_unit_tb failed");
        $finish;
    end

endmodule

>>> filelist.f
design/glcw_pkg.sv
design/glcw_ctrl.sv
design/glcw_datapath.sv
design/grid_line_cell_walk_unit.sv
design/glcw_checker.sv
tb/sv/grid_line_cell_walk_unit_tb.sv
